/* src/sliding_window_maximum_unit_defines.svh */
// Assertion macros shared by the sliding window maximum checkers.
// No dependencies; expects clk_i and rst_ni in the using scope.
`ifndef SLIDING_WINDOW_MAXIMUM_UNIT_DEFINES_SVH
`define SLIDING_WINDOW_MAXIMUM_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SWM_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("swm assertion failed");

// Next-cycle implication, disabled during reset.
`define SWM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("swm assertion failed");

`endif

/* src/swm_pkg.sv */
// Shared types and constants of the sliding window maximum unit.
// No dependencies.
`default_nettype none

package swm_pkg;

  localparam int unsigned SampleW = 32;
  localparam int unsigned PosW    = 32;
  localparam int unsigned WinCfgW = 7;

  typedef struct packed {
    logic signed [SampleW-1:0] sample;
    logic                      last_in_sequence;
  } swm_in_t;

  typedef struct packed {
    logic signed [SampleW-1:0] window_max;
    logic                      last_result;
  } swm_out_t;

  typedef struct packed {
    logic signed [SampleW-1:0] value;
    logic [PosW-1:0]           position;
  } swm_entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXPIRE,
    ST_POP,
    ST_APPEND,
    ST_FRONT,
    ST_RESULT
  } swm_state_e;

endpackage

`default_nettype wire

/* src/swm_store.sv */
// Deque entry store: one write port and one read port with registered read data.
// Depends on swm_pkg for the entry type.
`default_nettype none

module swm_store #(
  parameter int unsigned Depth = 64,
  parameter int unsigned AddrW = 6
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [AddrW-1:0]    waddr_i,
  input  swm_pkg::swm_entry_t wdata_i,
  input  logic [AddrW-1:0]    raddr_i,
  output swm_pkg::swm_entry_t rdata_o
);
  import swm_pkg::*;

  swm_entry_t mem_q [Depth];
  swm_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* src/swm_ctrl.sv */
// Deque sequencer: expiry, back removal, append and front read over the entry store.
// Depends on swm_pkg for types and states.
`default_nettype none

module swm_ctrl #(
  parameter int unsigned MaxWindow = 64,
  parameter int unsigned AddrW     = 6
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  swm_pkg::swm_in_t           in_i,
  input  logic [swm_pkg::WinCfgW-1:0] k_i,
  output logic                       res_valid_o,
  input  logic                       res_ready_i,
  output swm_pkg::swm_out_t          res_o,
  output logic                       we_o,
  output logic [AddrW-1:0]           waddr_o,
  output swm_pkg::swm_entry_t        wdata_o,
  output logic [AddrW-1:0]           raddr_o,
  input  swm_pkg::swm_entry_t        rdata_i
);
  import swm_pkg::*;

  localparam int unsigned CntW = $clog2(MaxWindow + 1);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(MaxWindow - 1);
  localparam logic [CntW-1:0]  FullCnt  = CntW'(MaxWindow);

  function automatic logic [AddrW-1:0] nxt(input logic [AddrW-1:0] p);
    nxt = (p == LastAddr) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [AddrW-1:0] prv(input logic [AddrW-1:0] p);
    prv = (p == '0) ? LastAddr : p - 1'b1;
  endfunction

  swm_state_e      state_q, state_d;
  logic [AddrW-1:0] front_q, front_d;
  logic [AddrW-1:0] back_q, back_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [PosW-1:0]  pos_q, pos_d;
  swm_in_t          cur_q, cur_d;
  logic             emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      front_q <= '0;
      back_q  <= '0;
      count_q <= '0;
      pos_q   <= '0;
    end else begin
      state_q <= state_d;
      front_q <= front_d;
      back_q  <= back_d;
      count_q <= count_d;
      pos_q   <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
  end

  assign in_stall_o = (state_q != ST_IDLE);
  assign emit = ({1'b0, pos_q} + (PosW + 1)'(1)) >= (PosW + 1)'(k_i);

  always_comb begin
    state_d = state_q;
    front_d = front_q;
    back_d  = back_q;
    count_d = count_q;
    pos_d   = pos_q;
    cur_d   = cur_q;
    raddr_o = front_q;
    we_o    = 1'b0;
    waddr_o = back_q;
    wdata_o.value    = cur_q.sample;
    wdata_o.position = pos_q;
    res_valid_o = 1'b0;
    res_o.window_max  = rdata_i.value;
    res_o.last_result = cur_q.last_in_sequence;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cur_d   = in_i;
          state_d = ST_EXPIRE;
        end
      end
      ST_EXPIRE: begin
        if (count_q != '0 && (pos_q - rdata_i.position) >= PosW'(k_i)) begin
          front_d = nxt(front_q);
          count_d = count_q - 1'b1;
        end
        if (count_d != '0) begin
          raddr_o = prv(back_q);
          state_d = ST_POP;
        end else begin
          state_d = ST_APPEND;
        end
      end
      ST_POP: begin
        if ($signed(rdata_i.value) < $signed(cur_q.sample)) begin
          back_d  = prv(back_q);
          count_d = count_q - 1'b1;
          if (count_d != '0) begin
            raddr_o = prv(back_d);
          end else begin
            state_d = ST_APPEND;
          end
        end else begin
          state_d = ST_APPEND;
        end
      end
      ST_APPEND: begin
        we_o   = 1'b1;
        back_d = nxt(back_q);
        if (count_q == FullCnt) begin
          front_d = nxt(front_q);
        end else begin
          count_d = count_q + 1'b1;
        end
        state_d = ST_FRONT;
      end
      ST_FRONT: begin
        state_d = ST_RESULT;
      end
      ST_RESULT: begin
        res_valid_o = emit;
        if (!emit || res_ready_i) begin
          pos_d = pos_q + 1'b1;
          if (cur_q.last_in_sequence) begin
            front_d = '0;
            back_d  = '0;
            count_d = '0;
            pos_d   = '0;
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* src/sliding_window_maximum_unit.sv */
// Top level of the sliding window maximum unit: window register, output register.
// Depends on swm_pkg, swm_store and swm_ctrl.
//
// Channel  Direction  Handshake        Payload
// in       input      in_valid/stall   swm_in_t: sample, last_in_sequence
// out      output     out_valid/stall  swm_out_t: window_max, last_result
// cfg      input      cfg_valid/ready  window_size, 7 bits
//
// An item passes the expiry check, one compare against a back entry per loop pass,
// the append, the front read and the result; the compare loop over the entry store
// reads through the registered port and runs at most once for each entry held.
// Reset empties the deque at once; the entry store needs no clearing pass.
// A stalled output holds the next result in the sequencer until the register frees.
`default_nettype none

module sliding_window_maximum_unit #(
  parameter int unsigned MAX_WINDOW = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  swm_pkg::swm_in_t            in_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output swm_pkg::swm_out_t           out_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [swm_pkg::WinCfgW-1:0] cfg_data_i
);
  import swm_pkg::*;

  localparam int unsigned AddrW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

  logic [WinCfgW-1:0] window_q;
  logic [WinCfgW-1:0] k;
  logic               out_valid_q;
  swm_out_t           out_q;
  logic               res_valid;
  logic               res_ready;
  swm_out_t           res;
  logic               we;
  logic [AddrW-1:0]   waddr;
  logic [AddrW-1:0]   raddr;
  swm_entry_t         wdata;
  swm_entry_t         rdata;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= WinCfgW'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      window_q <= cfg_data_i;
    end
  end

  always_comb begin
    if (window_q == '0) begin
      k = WinCfgW'(1);
    end else if (32'(window_q) > 32'(MAX_WINDOW)) begin
      k = WinCfgW'(MAX_WINDOW);
    end else begin
      k = window_q;
    end
  end

  assign res_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  swm_ctrl #(
    .MaxWindow(MAX_WINDOW),
    .AddrW    (AddrW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_i       (in_i),
    .k_i        (k),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .res_o      (res),
    .we_o       (we),
    .waddr_o    (waddr),
    .wdata_o    (wdata),
    .raddr_o    (raddr),
    .rdata_i    (rdata)
  );

  swm_store #(
    .Depth(MAX_WINDOW),
    .AddrW(AddrW)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

endmodule

`default_nettype wire

/* src/swm_checker.sv */
// Port-level checker for the sliding window maximum unit, bound to the top level.
// Depends on swm_pkg and sliding_window_maximum_unit_defines.svh.
`default_nettype none
`include "sliding_window_maximum_unit_defines.svh"

module swm_checker (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_stall_o,
  input wire logic              out_valid_o,
  input wire logic              out_stall_i,
  input wire swm_pkg::swm_out_t out_o
);

  // A stalled result transfer keeps its payload.
  `SWM_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_o))

  // The unit works on one sample at a time after an input transfer.
  `SWM_ASSERT_NEXT(a_busy_after_in, in_valid_i && !in_stall_o, in_stall_o)

  // No new result can appear in the cycle after an input transfer.
  `SWM_ASSERT_NEXT(a_no_instant_result, in_valid_i && !in_stall_o,
                   !out_valid_o || $past(out_valid_o))

  // A result only appears while a sample is being processed.
  `SWM_ASSERT_SAME(a_result_from_busy, $rose(out_valid_o), $past(in_stall_o))

endmodule

bind sliding_window_maximum_unit swm_checker u_swm_checker (.*);

`default_nettype wire
